[design/medr_pkg.sv]
package medr_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned RawW    = 16;
  localparam int unsigned ChanW   = 3;
  localparam int unsigned ShiftW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 12;

  localparam logic [CfgIdxW-1:0] REG_SMOOTHING_SHIFT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_REPORT_THRESHOLD = 2'd1;

  localparam logic [ShiftW-1:0]  SHIFT_RESET     = 4'd3;
  localparam logic [SampleW-1:0] THRESHOLD_RESET = 12'd8;

  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_SNAPSHOT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SNAP
  } state_e;

  typedef struct packed {
    logic [SampleW-1:0] last_rep;
    logic [SampleW-1:0] filt;
  } entry_t;

endpackage

[design/medr_ram.sv]
module medr_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/multichannel_ema_deadband_reporter.sv]
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o  op_i, channel_i, sample_i
// out       output     out_valid_o / out_stall_i out_channel_o, filtered_value_o,
//                                                from_snapshot_o, last_of_run_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample first reads its channel entry from the state RAM, then updates it and writes
// it back. A snapshot reads the first RAM entry and then works through the entries in turn.
// A sample for a channel of CHANNELS or above is accepted while idle and has no effect.
// Reset clears the state, the snapshot index, the output valid and the primed flags and
// loads the default shift and threshold; a snapshot reports unprimed channels as zero.
// A stalled output holds the block in place until the transfer completes.
module multichannel_ema_deadband_reporter import medr_pkg::*; #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [ChanW-1:0]   channel_i,
  input  logic [RawW-1:0]    sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ChanW-1:0]   out_channel_o,
  output logic [SampleW-1:0] filtered_value_o,
  output logic               from_snapshot_o,
  output logic               last_of_run_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CHANNELS - 1);

  state_e state_q, state_d;

  logic [ShiftW-1:0]  shift_q;
  logic [SampleW-1:0] thresh_q;

  logic [CHANNELS-1:0] primed_q, primed_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]     ch_q, ch_d;
  logic [SampleW-1:0]  x_q, x_d;

  logic               out_valid_q, out_valid_d;
  logic [ChanW-1:0]   out_ch_q, out_ch_d;
  logic [SampleW-1:0] out_val_q, out_val_d;
  logic               out_snap_q, out_snap_d;
  logic               out_last_q, out_last_d;
  logic               out_load;
  logic               out_free;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, ram_rdata;

  logic                in_accept;
  logic                ch_ok;
  logic [IdxW-1:0]     ch_idx;
  logic signed [12:0]  diff;
  logic signed [12:0]  step;
  logic [SampleW-1:0]  y_new;
  logic [SampleW-1:0]  delta;
  logic                report;
  logic [SampleW-1:0]  snap_val;

  medr_ram #(
    .Width($bits(entry_t)),
    .Depth(CHANNELS)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign ch_ok       = 32'(channel_i) < CHANNELS;
  assign ch_idx      = IdxW'(channel_i);

  assign diff   = $signed({1'b0, x_q}) - $signed({1'b0, ram_rdata.filt});
  assign step   = diff >>> shift_q;
  assign y_new  = ram_rdata.filt + step[SampleW-1:0];
  assign delta  = (y_new > ram_rdata.last_rep) ? (y_new - ram_rdata.last_rep)
                                               : (ram_rdata.last_rep - y_new);
  assign report = delta > thresh_q;

  assign snap_val = primed_q[idx_q] ? ram_rdata.filt : '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (op_i == OP_SNAPSHOT) begin
            state_d = ST_SNAP;
          end else if (ch_ok) begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SNAP: begin
        if (out_free && (idx_q == LastIdx)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    primed_d   = primed_q;
    idx_d      = idx_q;
    ch_d       = ch_q;
    x_d        = x_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = ch_q;
    ram_raddr  = ch_idx;
    ram_wdata  = '{last_rep: x_q, filt: x_q};
    out_load   = 1'b0;
    out_ch_d   = ChanW'(ch_q);
    out_val_d  = y_new;
    out_snap_d = 1'b0;
    out_last_d = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          ch_d   = ch_idx;
          x_d    = sample_i[SampleW-1:0];
          idx_d  = '0;
          ram_re = (op_i == OP_SNAPSHOT) || ch_ok;
          if (op_i == OP_SNAPSHOT) begin
            ram_raddr = '0;
          end
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          ram_we = 1'b1;
          if (!primed_q[ch_q]) begin
            primed_d[ch_q] = 1'b1;
          end else begin
            ram_wdata.filt     = y_new;
            ram_wdata.last_rep = report ? y_new : ram_rdata.last_rep;
            out_load           = report;
          end
        end
      end
      ST_SNAP: begin
        if (out_free) begin
          ram_we     = 1'b1;
          ram_waddr  = idx_q;
          ram_wdata  = '{last_rep: snap_val, filt: snap_val};
          out_load   = 1'b1;
          out_ch_d   = ChanW'(idx_q);
          out_val_d  = snap_val;
          out_snap_d = 1'b1;
          out_last_d = (idx_q == LastIdx);
          if (idx_q != LastIdx) begin
            idx_d     = idx_q + IdxW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q + IdxW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      primed_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      shift_q     <= SHIFT_RESET;
      thresh_q    <= THRESHOLD_RESET;
    end else begin
      state_q     <= state_d;
      primed_q    <= primed_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_SMOOTHING_SHIFT) begin
          shift_q <= cfg_data_i[ShiftW-1:0];
        end else if (cfg_index_i == REG_REPORT_THRESHOLD) begin
          thresh_q <= cfg_data_i[SampleW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
    x_q  <= x_d;
    if (out_load) begin
      out_ch_q   <= out_ch_d;
      out_val_q  <= out_val_d;
      out_snap_q <= out_snap_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_channel_o    = out_ch_q;
  assign filtered_value_o = out_val_q;
  assign from_snapshot_o  = out_snap_q;
  assign last_of_run_o    = out_last_q;

endmodule

[design/medr_checker.sv]
module medr_checker import medr_pkg::*; #(
  parameter int unsigned Channels = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               op_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [ChanW-1:0]   out_channel_o,
  input logic [SampleW-1:0] filtered_value_o,
  input logic               from_snapshot_o,
  input logic               last_of_run_o
);

  // A snapshot keeps the input side stalled while it sweeps the channels.
  a_snap_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_SNAPSHOT) |=> in_stall_o)
    else $error("snapshot transfer not followed by an input stall");

  // A deadband report is always a single result.
  a_report_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !from_snapshot_o |-> last_of_run_o)
    else $error("deadband report without last_of_run");

  // The final snapshot result carries the highest channel number.
  a_snap_last_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && from_snapshot_o && last_of_run_o |-> out_channel_o == ChanW'(Channels - 1))
    else $error("snapshot ended on the wrong channel");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_value_o)
      && $stable(out_channel_o))
    else $error("stalled result changed");

endmodule

bind multichannel_ema_deadband_reporter medr_checker #(
  .Channels(CHANNELS)
) u_medr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .op_i            (op_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_channel_o   (out_channel_o),
  .filtered_value_o(filtered_value_o),
  .from_snapshot_o (from_snapshot_o),
  .last_of_run_o   (last_of_run_o)
);

[tb/multichannel_ema_deadband_reporter_test.sv]
module multichannel_ema_deadband_reporter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import medr_pkg::*;

  localparam int unsigned NumChannels = 8;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ItemsPerPhase = 40;

  typedef struct packed {
    logic [ChanW-1:0]   chan;
    logic [SampleW-1:0] value;
    logic               snap;
    logic               last;
  } report_t;

  class deadband_scoreboard;
    logic [SampleW-1:0] filt [NumChannels];
    logic [SampleW-1:0] last_rep [NumChannels];
    bit                 primed [NumChannels];
    logic [ShiftW-1:0]  shift;
    logic [SampleW-1:0] threshold;
    report_t            pending[$];
    int unsigned        mismatches;

    function new();
      shift = SHIFT_RESET;
      threshold = THRESHOLD_RESET;
      mismatches = 0;
      for (int i = 0; i < NumChannels; i++) begin
        filt[i] = '0;
        last_rep[i] = '0;
        primed[i] = 1'b0;
      end
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
      case (idx)
        REG_SMOOTHING_SHIFT: shift = data[ShiftW-1:0];
        REG_REPORT_THRESHOLD: threshold = data[SampleW-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic op, logic [ChanW-1:0] ch, logic [RawW-1:0] raw);
      logic [SampleW-1:0] x;
      logic [SampleW-1:0] y;
      logic [SampleW-1:0] delta;
      int diff;
      x = raw[SampleW-1:0];
      if (op == OP_SNAPSHOT) begin
        for (int i = 0; i < NumChannels; i++) begin
          last_rep[i] = filt[i];
          pending.push_back('{ChanW'(i), filt[i], 1'b1, (i == NumChannels - 1)});
        end
        return;
      end
      if (ch >= NumChannels) return;
      if (!primed[ch]) begin
        filt[ch] = x;
        last_rep[ch] = x;
        primed[ch] = 1'b1;
        return;
      end
      diff = int'(x) - int'(filt[ch]);
      y = SampleW'(int'(filt[ch]) + (diff >>> shift));
      filt[ch] = y;
      delta = (y > last_rep[ch]) ? y - last_rep[ch] : last_rep[ch] - y;
      if (delta > threshold) begin
        last_rep[ch] = y;
        pending.push_back('{ch, y, 1'b0, 1'b1});
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: expected none, ", $time,
                 "actual ch=%0d value=%0d snap=%0b last=%0b",
                 got.chan, got.value, got.snap, got.last);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.chan !== want.chan || got.value !== want.value ||
          got.snap !== want.snap || got.last !== want.last) begin
        $display("%0t: mismatch: expected ch=%0d value=%0d snap=%0b last=%0b, ",
                 $time, want.chan, want.value, want.snap, want.last,
                 "actual ch=%0d value=%0d snap=%0b last=%0b",
                 got.chan, got.value, got.snap, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = OP_SAMPLE;
  logic [ChanW-1:0]   channel = '0;
  logic [RawW-1:0]    sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ChanW-1:0]   out_channel;
  logic [SampleW-1:0] filtered_value;
  logic               from_snapshot;
  logic               last_of_run;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDatW-1:0] cfg_data = '0;

  int unsigned send_gap_pct = 10;
  int unsigned recv_stall_pct = 84;
  int unsigned quiet_cycles = 0;

  deadband_scoreboard tracker = new();

  multichannel_ema_deadband_reporter #(.CHANNELS(NumChannels)) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (op),
    .channel_i        (channel),
    .sample_i         (sample),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_channel_o    (out_channel),
    .filtered_value_o (filtered_value),
    .from_snapshot_o  (from_snapshot),
    .last_of_run_o    (last_of_run),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_report('{out_channel, filtered_value, from_snapshot, last_of_run});
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(logic item_op, logic [ChanW-1:0] ch, logic [RawW-1:0] raw);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= item_op;
    channel <= ch;
    sample <= raw;
    do @(posedge clk); while (in_stall);
    tracker.note_item(item_op, ch, raw);
  endtask

  task automatic send_random_item();
    logic             item_op;
    logic [ChanW-1:0] ch;
    logic [RawW-1:0]  raw;
    int               level;
    item_op = ($urandom_range(99) < 8) ? OP_SNAPSHOT : OP_SAMPLE;
    ch = ChanW'($urandom_range(NumChannels - 1));
    case ($urandom_range(3))
      0: raw = RawW'($urandom());
      3: begin
        case ($urandom_range(3))
          0: raw = 16'h0000;
          1: raw = 16'hFFFF;
          2: raw = 16'h0FFF;
          default: raw = 16'hF000;
        endcase
      end
      default: begin
        level = int'(tracker.filt[ch]) + int'($urandom_range(80)) - 40;
        if (level < 0) level = 0;
        if (level > 4095) level = 4095;
        raw = {4'($urandom()), SampleW'(level)};
      end
    endcase
    send_item(item_op, ch, raw);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_settings(logic [ShiftW-1:0] shift, logic [SampleW-1:0] threshold);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SMOOTHING_SHIFT;
    cfg_data <= CfgDatW'(shift);
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(REG_SMOOTHING_SHIFT, CfgDatW'(shift));
    cfg_index <= REG_REPORT_THRESHOLD;
    cfg_data <= CfgDatW'(threshold);
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(REG_REPORT_THRESHOLD, CfgDatW'(threshold));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_SNAPSHOT, 3'd5, 16'hA5A5);
    send_item(OP_SAMPLE, 3'd0, 16'hFFFF);
    send_item(OP_SAMPLE, 3'd7, 16'h0000);
    send_item(OP_SAMPLE, 3'd0, 16'h0000);
    send_item(OP_SAMPLE, 3'd7, 16'hFFFF);
    send_item(OP_SAMPLE, 3'd7, 16'hF1FF);
    send_item(OP_SNAPSHOT, 3'd0, 16'h0000);
    send_item(OP_SAMPLE, 3'd3, 16'h0800);
    send_item(OP_SAMPLE, 3'd3, 16'h0840);
    send_item(OP_SAMPLE, 3'd3, 16'h0848);
    send_item(OP_SAMPLE, 3'd1, 16'h1234);
    send_item(OP_SAMPLE, 3'd2, 16'hABCD);
    send_item(OP_SAMPLE, 3'd4, 16'h5555);
    send_item(OP_SAMPLE, 3'd5, 16'hAAAA);
    send_item(OP_SAMPLE, 3'd6, 16'h7FFF);
    send_item(OP_SNAPSHOT, 3'd7, 16'hFFFF);
    send_item(OP_SAMPLE, 3'd1, 16'h0000);
    send_item(OP_SAMPLE, 3'd2, 16'hFFFF);
    send_item(OP_SNAPSHOT, 3'd2, 16'h5A5A);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: write_settings(4'd0, 12'd0);
        1: write_settings(4'd12, 12'd4095);
        2: write_settings(4'd15, 12'd0);
        3: write_settings(ShiftW'($urandom_range(12)), SampleW'($urandom_range(63)));
        4: write_settings(4'd1, 12'd2);
        default: write_settings(SHIFT_RESET, THRESHOLD_RESET);
      endcase
      if (phase < 2) begin
        send_gap_pct = 10;
        recv_stall_pct = 84;
      end else if (phase < 4) begin
        send_gap_pct = 84;
        recv_stall_pct = 10;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      repeat (ItemsPerPhase) send_random_item();
    end

    drain();
    if (tracker.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
design/medr_pkg.sv
design/medr_ram.sv
design/multichannel_ema_deadband_reporter.sv
design/medr_checker.sv
tb/multichannel_ema_deadband_reporter_test.sv
